[hw/rtl/gnp_pkg.sv]
`default_nettype none
package gnp_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int FRAC_BITS     = 16;

    localparam int IDX_W    = $clog2(TABLE_ENTRIES);
    localparam int COORD_W  = 32;
    localparam int NOISE_W  = 16;
    localparam int DIM_W    = 2;
    localparam int CORNERS  = 8;
    localparam int AXES     = 3;

    // datapath widths
    localparam int GRAD_W   = FRAC_BITS + 3;
    localparam int DIFF_W   = GRAD_W + 1;
    localparam int FADE_W   = FRAC_BITS + 1;
    localparam int PROD_W   = FADE_W + 1 + DIFF_W;
    localparam int TT_W     = 2 * FRAC_BITS;
    localparam int QS_W     = 2 * FRAC_BITS + 5;
    localparam int Q_W      = FRAC_BITS + 5;
    localparam int FP_W     = FRAC_BITS + Q_W;
    localparam int SCALE_R  = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
    localparam int SCALE_L  = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
    localparam int SAT_W    = GRAD_W + SCALE_L + 1;
    localparam int NOISE_MAX = 2 ** (NOISE_W - 1) - 1;
    localparam int NOISE_MIN = -(2 ** (NOISE_W - 1));

    // queues
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int OUT_DEPTH  = 16;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);

    // codes
    localparam logic CMD_EVAL = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [DIM_W-1:0] DIM_ONE   = 2'd1;
    localparam logic [DIM_W-1:0] DIM_TWO   = 2'd2;
    localparam logic [DIM_W-1:0] DIM_THREE = 2'd3;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_THREE;

    localparam int          PADDR_W      = 3;
    localparam logic        REG_DIMS_SEL = 1'b0;

    typedef struct packed {
        logic                       command;
        logic signed [COORD_W-1:0]  coord_x;
        logic signed [COORD_W-1:0]  coord_y;
        logic signed [COORD_W-1:0]  coord_z;
        logic [IDX_W-1:0]           entry_index;
        logic [IDX_W-1:0]           entry_value;
    } t_cmd;

    // back end to output queue
    typedef struct packed {
        logic                       issue_eval;
        logic                       push;
        logic signed [NOISE_W-1:0]  noise_value;
    } t_bk_flow;

endpackage
`default_nettype wire

[hw/rtl/gnp_if.sv]
`default_nettype none
interface gnp_in_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   command;
    logic signed [gnp_pkg::COORD_W-1:0]     coord_x;
    logic signed [gnp_pkg::COORD_W-1:0]     coord_y;
    logic signed [gnp_pkg::COORD_W-1:0]     coord_z;
    logic [gnp_pkg::IDX_W-1:0]              entry_index;
    logic [gnp_pkg::IDX_W-1:0]              entry_value;

    modport source (output valid, command, coord_x, coord_y, coord_z, entry_index,
                    entry_value, input ready);
    modport sink   (input valid, command, coord_x, coord_y, coord_z, entry_index,
                    entry_value, output ready);
endinterface

interface gnp_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [gnp_pkg::NOISE_W-1:0]     noise_value;

    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface
`default_nettype wire

[hw/rtl/gnp_front.sv]
`default_nettype none
// command queue: takes transactions and holds them for the back end
module gnp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    gnp_in_if.sink              i_in,
    input  wire logic           i_pop,
    output gnp_pkg::t_cmd       o_head,
    output logic                o_head_valid
);

    gnp_pkg::t_cmd                  r_q [gnp_pkg::CMDQ_DEPTH];
    logic [gnp_pkg::CMDQ_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [gnp_pkg::CMDQ_PTR_W:0]   r_cnt, n_cnt;
    logic                           push, pop;
    gnp_pkg::t_cmd                  in_cmd;

    always_comb begin
        in_cmd.command     = i_in.command;
        in_cmd.coord_x     = i_in.coord_x;
        in_cmd.coord_y     = i_in.coord_y;
        in_cmd.coord_z     = i_in.coord_z;
        in_cmd.entry_index = i_in.entry_index;
        in_cmd.entry_value = i_in.entry_value;
    end

    assign i_in.ready   = (r_cnt != (gnp_pkg::CMDQ_PTR_W+1)'(gnp_pkg::CMDQ_DEPTH));
    assign push         = i_in.valid & i_in.ready;
    assign o_head_valid = (r_cnt != '0);
    assign pop          = i_pop & o_head_valid;
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= in_cmd;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/gnp_back.sv]
`default_nettype none
// execution pipeline: table lookups (three levels, replicated tables), fade, gradients,
// three lerp levels, rescale and saturate
module gnp_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [gnp_pkg::DIM_W-1:0]  i_dims,
    input  gnp_pkg::t_cmd                   i_head,
    input  wire logic                       i_head_valid,
    input  wire logic                       i_room,
    output logic                            o_pop,
    output gnp_pkg::t_bk_flow               o_flow
);

    localparam int F = gnp_pkg::FRAC_BITS;
    localparam int N = gnp_pkg::TABLE_ENTRIES;
    localparam int IW = gnp_pkg::IDX_W;
    localparam int GW = gnp_pkg::GRAD_W;
    localparam int DW = gnp_pkg::DIFF_W;
    localparam int PW = gnp_pkg::PROD_W;
    localparam int FW = gnp_pkg::FADE_W;

    typedef logic signed [GW-1:0] t_g;

    function automatic t_g grad(input logic [gnp_pkg::DIM_W-1:0] dims,
                                input logic [IW-1:0] h, input t_g x, input t_g y,
                                input t_g z);
        t_g  u, v;
        logic [3:0] hl;
        hl = h[3:0];
        u  = x;
        v  = y;
        if (dims == gnp_pkg::DIM_THREE) begin
            u = (hl < 4'd8) ? x : y;
            v = (hl < 4'd4) ? y : ((hl == 4'd12 || hl == 4'd14) ? x : z);
            return (hl[0] ? -u : u) + (hl[1] ? -v : v);
        end else if (dims == gnp_pkg::DIM_TWO) begin
            return (h[0] ? -x : x) + (h[1] ? -y : y);
        end
        return h[0] ? x : -x;
    endfunction

    function automatic logic signed [PW-1:0] lerp_mul(input logic [FW-1:0] t, input t_g a,
                                                      input t_g b);
        logic signed [DW-1:0] d;
        d = DW'(b) - DW'(a);
        return PW'($signed({1'b0, t})) * PW'(d);
    endfunction

    function automatic t_g lerp_add(input t_g a, input logic signed [PW-1:0] p);
        logic signed [PW-1:0] s;
        s = p >>> F;
        return a + GW'(s);
    endfunction

    // replicated permutation tables
    logic [IW-1:0] r_tab_a [N];
    logic [IW-1:0] r_tab_b [2][N];
    logic [IW-1:0] r_tab_c [4][N];

    // issue
    logic                       issue;
    logic [gnp_pkg::DIM_W-1:0]  dims_eff;
    logic [IW-1:0]              xi, xi1;
    logic [F-1:0]               f_c [gnp_pkg::AXES];

    // stage 1
    logic                       r_s1_vld, r_s1_load;
    logic [gnp_pkg::DIM_W-1:0]  r_s1_dims;
    logic [IW-1:0]              r_s1_idx, r_s1_val, r_s1_yi, r_s1_zi;
    logic [F-1:0]               r_s1_f [gnp_pkg::AXES];
    logic [gnp_pkg::TT_W-1:0]   r_s1_tt [gnp_pkg::AXES];
    logic [IW-1:0]              r_rd_a0, r_rd_a1;
    logic [IW-1:0]              ad_b [4];
    logic [gnp_pkg::TT_W-1:0]   t3p_c [gnp_pkg::AXES];
    logic [gnp_pkg::Q_W-1:0]    q_c [gnp_pkg::AXES];

    // stage 2
    logic                       r_s2_vld, r_s2_load;
    logic [gnp_pkg::DIM_W-1:0]  r_s2_dims;
    logic [IW-1:0]              r_s2_idx, r_s2_val, r_s2_zi, r_s2_pa, r_s2_pb;
    logic [F-1:0]               r_s2_f [gnp_pkg::AXES];
    logic [gnp_pkg::TT_W-1:0]   r_s2_t3p [gnp_pkg::AXES];
    logic [gnp_pkg::Q_W-1:0]    r_s2_q [gnp_pkg::AXES];
    logic [IW-1:0]              r_rd_b [4];
    logic [IW-1:0]              ad_c [4];
    logic [FW-1:0]              fade_c [gnp_pkg::AXES];

    // stage 3
    logic                       r_s3_vld;
    logic [gnp_pkg::DIM_W-1:0]  r_s3_dims;
    logic [IW-1:0]              r_s3_pa, r_s3_pb;
    logic [IW-1:0]              r_s3_hb [4];
    logic [F-1:0]               r_s3_f [gnp_pkg::AXES];
    logic [FW-1:0]              r_s3_fade [gnp_pkg::AXES];
    logic [IW-1:0]              r_rd_c [gnp_pkg::CORNERS];
    logic [IW-1:0]              hash_c [gnp_pkg::CORNERS];
    t_g                         lo_c [gnp_pkg::AXES];
    t_g                         hi_c [gnp_pkg::AXES];

    // stages 4..9
    logic                       r_s4_vld, r_s5_vld, r_s6_vld, r_s7_vld, r_s8_vld, r_s9_vld;
    t_g                         r_s4_g [gnp_pkg::CORNERS];
    logic [FW-1:0]              r_s4_u, r_s4_v, r_s4_w;
    logic signed [PW-1:0]       r_s5_p [4];
    t_g                         r_s5_a [4];
    logic [FW-1:0]              r_s5_v, r_s5_w, r_s6_v, r_s6_w, r_s7_w, r_s8_w;
    t_g                         r_s6_l [4];
    logic signed [PW-1:0]       r_s7_p [2];
    t_g                         r_s7_a [2];
    t_g                         r_s8_m [2];
    logic signed [PW-1:0]       r_s9_p;
    t_g                         r_s9_a;
    t_g                         res_c;
    logic signed [gnp_pkg::SAT_W-1:0] scaled_c;
    logic signed [gnp_pkg::NOISE_W-1:0] noise_c;

    // ---------------- issue ----------------
    assign issue = i_head_valid && (i_head.command == gnp_pkg::CMD_LOAD || i_room);
    assign o_pop = issue;
    assign xi    = i_head.coord_x[F+IW-1:F];
    assign xi1   = xi + IW'(1);

    always_comb begin
        f_c[0] = i_head.coord_x[F-1:0];
        f_c[1] = i_head.coord_y[F-1:0];
        f_c[2] = i_head.coord_z[F-1:0];
        unique case (i_dims)
            gnp_pkg::DIM_THREE: dims_eff = gnp_pkg::DIM_THREE;
            gnp_pkg::DIM_TWO:   dims_eff = gnp_pkg::DIM_TWO;
            default:            dims_eff = gnp_pkg::DIM_ONE;
        endcase
    end

    // ---------------- stage 1 comb ----------------
    always_comb begin
        ad_b[0] = r_rd_a0 + r_s1_yi;
        ad_b[1] = ad_b[0] + IW'(1);
        ad_b[2] = r_rd_a1 + r_s1_yi;
        ad_b[3] = ad_b[2] + IW'(1);
        for (int k = 0; k < gnp_pkg::AXES; k++) begin
            t3p_c[k] = gnp_pkg::TT_W'(r_s1_tt[k] >> F) * gnp_pkg::TT_W'(r_s1_f[k]);
            q_c[k]   = gnp_pkg::Q_W'((((gnp_pkg::QS_W'(r_s1_tt[k]) << 2)
                                      + (gnp_pkg::QS_W'(r_s1_tt[k]) << 1))
                                     + (gnp_pkg::QS_W'(10) << (2 * F))
                                     - (((gnp_pkg::QS_W'(r_s1_f[k]) << 4)
                                         - gnp_pkg::QS_W'(r_s1_f[k])) << F)) >> F);
        end
    end

    // ---------------- stage 2 comb ----------------
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ad_c[k] = r_rd_b[k] + r_s2_zi;
        end
        for (int k = 0; k < gnp_pkg::AXES; k++) begin
            fade_c[k] = FW'((gnp_pkg::FP_W'(r_s2_t3p[k] >> F) * gnp_pkg::FP_W'(r_s2_q[k]))
                            >> F);
        end
    end

    // ---------------- stage 3 comb: hashes and gradients ----------------
    always_comb begin
        for (int c = 0; c < gnp_pkg::CORNERS; c++) begin
            hash_c[c] = r_rd_c[c];
        end
        if (r_s3_dims == gnp_pkg::DIM_TWO) begin
            hash_c[0] = r_s3_hb[0];
            hash_c[1] = r_s3_hb[2];
            hash_c[2] = r_s3_hb[1];
            hash_c[3] = r_s3_hb[3];
        end else if (r_s3_dims == gnp_pkg::DIM_ONE) begin
            hash_c[0] = r_s3_pa;
            hash_c[1] = r_s3_pb;
        end
        for (int k = 0; k < gnp_pkg::AXES; k++) begin
            lo_c[k] = GW'(r_s3_f[k]);
            hi_c[k] = GW'(r_s3_f[k]) - (GW'(1) <<< F);
        end
    end

    // ---------------- stage 9 comb: last lerp, rescale, saturate ----------------
    always_comb begin
        res_c    = lerp_add(r_s9_a, r_s9_p);
        scaled_c = (gnp_pkg::SAT_W'(res_c) >>> gnp_pkg::SCALE_R) <<< gnp_pkg::SCALE_L;
        if (scaled_c > gnp_pkg::SAT_W'(gnp_pkg::NOISE_MAX)) begin
            noise_c = gnp_pkg::NOISE_W'(gnp_pkg::NOISE_MAX);
        end else if (scaled_c < gnp_pkg::SAT_W'(gnp_pkg::NOISE_MIN)) begin
            noise_c = gnp_pkg::NOISE_W'(gnp_pkg::NOISE_MIN);
        end else begin
            noise_c = gnp_pkg::NOISE_W'(scaled_c);
        end
    end

    assign o_flow.issue_eval  = issue && (i_head.command == gnp_pkg::CMD_EVAL);
    assign o_flow.push        = r_s9_vld;
    assign o_flow.noise_value = noise_c;

    // ---------------- tables: each copy written when loads reach its read stage ----------
    always_ff @(posedge i_clk) begin
        if (issue && i_head.command == gnp_pkg::CMD_LOAD) begin
            r_tab_a[i_head.entry_index] <= i_head.entry_value;
        end
        r_rd_a0 <= r_tab_a[xi];
        r_rd_a1 <= r_tab_a[xi1];
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 2; k++) begin
            if (r_s1_vld && r_s1_load) begin
                r_tab_b[k][r_s1_idx] <= r_s1_val;
            end
            r_rd_b[2*k]   <= r_tab_b[k][ad_b[2*k]];
            r_rd_b[2*k+1] <= r_tab_b[k][ad_b[2*k+1]];
        end
    end

    // copy k serves one of aa, ba, ab, bb and its +1 neighbour (upper z corner)
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            if (r_s2_vld && r_s2_load) begin
                r_tab_c[k][r_s2_idx] <= r_s2_val;
            end
        end
        r_rd_c[0] <= r_tab_c[0][ad_c[0]];
        r_rd_c[4] <= r_tab_c[0][ad_c[0] + IW'(1)];
        r_rd_c[2] <= r_tab_c[1][ad_c[1]];
        r_rd_c[6] <= r_tab_c[1][ad_c[1] + IW'(1)];
        r_rd_c[1] <= r_tab_c[2][ad_c[2]];
        r_rd_c[5] <= r_tab_c[2][ad_c[2] + IW'(1)];
        r_rd_c[3] <= r_tab_c[3][ad_c[3]];
        r_rd_c[7] <= r_tab_c[3][ad_c[3] + IW'(1)];
    end

    // ---------------- pipeline control ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_s6_vld <= 1'b0;
            r_s7_vld <= 1'b0;
            r_s8_vld <= 1'b0;
            r_s9_vld <= 1'b0;
        end else begin
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld && !r_s2_load;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
            r_s6_vld <= r_s5_vld;
            r_s7_vld <= r_s6_vld;
            r_s8_vld <= r_s7_vld;
            r_s9_vld <= r_s8_vld;
        end
    end

    // ---------------- pipeline payload ----------------
    always_ff @(posedge i_clk) begin
        // stage 1
        r_s1_load <= (i_head.command == gnp_pkg::CMD_LOAD);
        r_s1_dims <= dims_eff;
        r_s1_idx  <= i_head.entry_index;
        r_s1_val  <= i_head.entry_value;
        r_s1_yi   <= i_head.coord_y[F+IW-1:F];
        r_s1_zi   <= i_head.coord_z[F+IW-1:F];
        for (int k = 0; k < gnp_pkg::AXES; k++) begin
            r_s1_f[k]  <= f_c[k];
            r_s1_tt[k] <= gnp_pkg::TT_W'(f_c[k]) * gnp_pkg::TT_W'(f_c[k]);
        end
        // stage 2
        r_s2_load <= r_s1_load;
        r_s2_dims <= r_s1_dims;
        r_s2_idx  <= r_s1_idx;
        r_s2_val  <= r_s1_val;
        r_s2_zi   <= r_s1_zi;
        r_s2_pa   <= r_rd_a0;
        r_s2_pb   <= r_rd_a1;
        for (int k = 0; k < gnp_pkg::AXES; k++) begin
            r_s2_f[k]   <= r_s1_f[k];
            r_s2_t3p[k] <= t3p_c[k];
            r_s2_q[k]   <= q_c[k];
        end
        // stage 3
        r_s3_dims <= r_s2_dims;
        r_s3_pa   <= r_s2_pa;
        r_s3_pb   <= r_s2_pb;
        for (int k = 0; k < 4; k++) begin
            r_s3_hb[k] <= r_rd_b[k];
        end
        for (int k = 0; k < gnp_pkg::AXES; k++) begin
            r_s3_f[k]    <= r_s2_f[k];
            r_s3_fade[k] <= fade_c[k];
        end
        // stage 4: gradients; unused axes get a zero weight
        for (int c = 0; c < gnp_pkg::CORNERS; c++) begin
            r_s4_g[c] <= grad(r_s3_dims, hash_c[c],
                              c[0] ? hi_c[0] : lo_c[0],
                              c[1] ? hi_c[1] : lo_c[1],
                              c[2] ? hi_c[2] : lo_c[2]);
        end
        r_s4_u <= r_s3_fade[0];
        r_s4_v <= (r_s3_dims == gnp_pkg::DIM_ONE) ? '0 : r_s3_fade[1];
        r_s4_w <= (r_s3_dims == gnp_pkg::DIM_THREE) ? r_s3_fade[2] : '0;
        // stages 5..6: x lerps
        for (int k = 0; k < 4; k++) begin
            r_s5_p[k] <= lerp_mul(r_s4_u, r_s4_g[2*k], r_s4_g[2*k+1]);
            r_s5_a[k] <= r_s4_g[2*k];
            r_s6_l[k] <= lerp_add(r_s5_a[k], r_s5_p[k]);
        end
        r_s5_v <= r_s4_v;
        r_s5_w <= r_s4_w;
        r_s6_v <= r_s5_v;
        r_s6_w <= r_s5_w;
        // stages 7..8: y lerps
        for (int k = 0; k < 2; k++) begin
            r_s7_p[k] <= lerp_mul(r_s6_v, r_s6_l[2*k], r_s6_l[2*k+1]);
            r_s7_a[k] <= r_s6_l[2*k];
            r_s8_m[k] <= lerp_add(r_s7_a[k], r_s7_p[k]);
        end
        r_s7_w <= r_s6_w;
        r_s8_w <= r_s7_w;
        // stage 9: z lerp product
        r_s9_p <= lerp_mul(r_s8_w, r_s8_m[0], r_s8_m[1]);
        r_s9_a <= r_s8_m[0];
    end

endmodule
`default_nettype wire

[hw/rtl/gnp_outq.sv]
`default_nettype none
// result queue with credit count: the back end issues an evaluate only when a slot is
// reserved for its result, so its pipeline never stalls
module gnp_outq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  gnp_pkg::t_bk_flow   i_flow,
    output logic                o_room,
    gnp_out_if.source           o_out
);

    logic signed [gnp_pkg::NOISE_W-1:0] r_mem [gnp_pkg::OUT_DEPTH];
    logic [gnp_pkg::OUT_PTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [gnp_pkg::OUT_PTR_W:0]        r_cnt, n_cnt, r_credit, n_credit;
    logic                               pop;

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.noise_value = r_mem[r_rd_ptr];
    assign pop               = o_out.valid & o_out.ready;
    assign o_room            = (r_credit < (gnp_pkg::OUT_PTR_W+1)'(gnp_pkg::OUT_DEPTH));

    always_comb begin
        n_cnt    = r_cnt + (gnp_pkg::OUT_PTR_W+1)'(i_flow.push)
                         - (gnp_pkg::OUT_PTR_W+1)'(pop);
        n_credit = r_credit + (gnp_pkg::OUT_PTR_W+1)'(i_flow.issue_eval)
                            - (gnp_pkg::OUT_PTR_W+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
            r_credit <= '0;
        end else begin
            r_cnt    <= n_cnt;
            r_credit <= n_credit;
            if (i_flow.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_flow.push) begin
            r_mem[r_wr_ptr] <= i_flow.noise_value;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_flow.push |-> (r_cnt != (gnp_pkg::OUT_PTR_W+1)'(gnp_pkg::OUT_DEPTH)))
        else $error("result pushed into a full queue");

    a_credit_covers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit >= r_cnt)
        else $error("credit count below queue fill");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= (gnp_pkg::OUT_PTR_W+1)'(gnp_pkg::OUT_DEPTH))
        else $error("credit count overflow");

    a_issue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_flow.issue_eval |-> o_room)
        else $error("evaluate issued without a reserved slot");

endmodule
`default_nettype wire

[hw/rtl/gradient_noise_perlin.sv]
`default_nettype none
// Channel   Dir  Handshake     Payload
// i_in      in   valid/ready   command, coord_x/y/z (s16.16), entry_index, entry_value
// o_out     out  valid/ready   noise_value (s2.14, saturated)
// apb       in   psel/penable  dimensions at byte address 0
//
// Sustained rate: one transaction per cycle, loads and evaluates alike, while the result
// queue has room. An accepted evaluate passes the command queue, the lookup/fade/lerp
// pipeline and the result queue; the pipeline depth is set by the three dependent table
// lookups and the three lerp levels, each a multiply and an add.
// Reset (synchronous, active low) empties both queues and sets dimensions to 3; the
// permutation table is not cleared and must be loaded before use.
// Output stalls fill a 16-entry result queue; evaluates are only issued against a
// free slot, so the pipeline itself never stalls.
module gradient_noise_perlin (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    gnp_in_if.sink                              i_in,
    gnp_out_if.source                           o_out,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gnp_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [gnp_pkg::DIM_W-1:0]  r_dims;
    gnp_pkg::t_cmd              head;
    logic                       head_valid;
    logic                       pop;
    logic                       room;
    gnp_pkg::t_bk_flow          flow;
    logic                       sel_dims;

    // register decode: only word 0 exists, higher words read as zero
    assign sel_dims = (paddr[gnp_pkg::PADDR_W-1] == gnp_pkg::REG_DIMS_SEL);
    assign pready   = 1'b1;
    assign prdata   = sel_dims ? {{(32-gnp_pkg::DIM_W){1'b0}}, r_dims} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= gnp_pkg::DIM_RESET;
        end else if (psel && penable && pwrite && pready && sel_dims) begin
            r_dims <= pwdata[gnp_pkg::DIM_W-1:0];
        end
    end

    // front: accepts transactions into a short queue
    gnp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid)
    );

    // back: table writes and the evaluate pipeline
    gnp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_dims       (r_dims),
        .i_head       (head),
        .i_head_valid (head_valid),
        .i_room       (room),
        .o_pop        (pop),
        .o_flow       (flow)
    );

    // result queue towards the consumer
    gnp_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flow  (flow),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gnp_pkg::*;

    // input acceptance to result valid, plus margin
    localparam int PIPE_LATENCY = 11;
    localparam int SETTLE       = PIPE_LATENCY + 6;
    // cycles with no transaction on the input, output or APB channel before giving up
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 400;

    // register map: dimensions at index 0, index 1 is unmapped
    localparam logic [PADDR_W-1:0] DIMS_ADDR  = PADDR_W'(4 * REG_DIMS_SEL);
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4);

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    gnp_in_if  in_ch ();
    gnp_out_if out_ch ();

    gradient_noise_perlin i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: own copy of the table and of the dimensions register
    logic [7:0]       perm_copy [TABLE_ENTRIES];
    logic [DIM_W-1:0] dims_copy;
    logic signed [NOISE_W-1:0] noise_expected [$];

    int mismatches = 0;
    int send_gap_pct = 0;
    int sink_stall_pct = 0;
    int idle_cycles = 0;

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.command     = CMD_EVAL;
        in_ch.coord_x     = '0;
        in_ch.coord_y     = '0;
        in_ch.coord_z     = '0;
        in_ch.entry_index = '0;
        in_ch.entry_value = '0;
        out_ch.ready      = 1'b0;
    end

    // ---------------------------------------------------------------
    // Noise predictor, 64-bit integer arithmetic; >>> on a signed
    // longint is a floor, which is what every truncation here wants.
    // ---------------------------------------------------------------
    function automatic longint perm_at(int i);
        return longint'(perm_copy[i & 255]);
    endfunction

    function automatic longint fade_curve(longint f);
        longint s, q, t2, t3;
        s  = longint'(1) <<< FRAC_BITS;
        q  = (6 * f * f + 10 * s * s - 15 * f * s) >>> FRAC_BITS;
        t2 = (f * f) >>> FRAC_BITS;
        t3 = (t2 * f) >>> FRAC_BITS;
        return (t3 * q) >>> FRAC_BITS;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return a + ((t * (b - a)) >>> FRAC_BITS);
    endfunction

    function automatic longint corner_dot(logic [DIM_W-1:0] dims, longint h,
                                          longint x, longint y, longint z);
        longint u, v;
        int h4;
        h4 = int'(h & 15);
        case (dims)
            DIM_TWO:   return ((h & 1) ? -x : x) + ((h & 2) ? -y : y);
            DIM_THREE: begin
                u = (h4 < 8) ? x : y;
                v = (h4 < 4) ? y : ((h4 == 12 || h4 == 14) ? x : z);
                return ((h4 & 1) ? -u : u) + ((h4 & 2) ? -v : v);
            end
            default:   return (h & 1) ? x : -x;
        endcase
    endfunction

    function automatic logic signed [NOISE_W-1:0] predict_noise(
            logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy, logic [COORD_W-1:0] cz);
        logic [DIM_W-1:0] dims;
        int xi, yi, zi, a, b, aa, ab, ba, bb;
        longint one, xf, yf, zf, x1, y1, z1, u, v, w, r, l1, l2, l3, l4;
        // dimensions zero behaves as one
        dims = (dims_copy == DIM_TWO || dims_copy == DIM_THREE) ? dims_copy : DIM_ONE;
        one = longint'(1) <<< FRAC_BITS;
        xi = int'(cx[FRAC_BITS +: 8]);
        yi = int'(cy[FRAC_BITS +: 8]);
        zi = int'(cz[FRAC_BITS +: 8]);
        xf = longint'(cx[FRAC_BITS-1:0]);
        yf = longint'(cy[FRAC_BITS-1:0]);
        zf = longint'(cz[FRAC_BITS-1:0]);
        x1 = xf - one; y1 = yf - one; z1 = zf - one;
        u = fade_curve(xf); v = fade_curve(yf); w = fade_curve(zf);
        if (dims == DIM_ONE) begin
            r = blend(corner_dot(dims, perm_at(xi), xf, 0, 0),
                      corner_dot(dims, perm_at(xi + 1), x1, 0, 0), u);
        end else if (dims == DIM_TWO) begin
            a  = int'(perm_at(xi));
            b  = int'(perm_at(xi + 1));
            l1 = blend(corner_dot(dims, perm_at(a + yi), xf, yf, 0),
                       corner_dot(dims, perm_at(b + yi), x1, yf, 0), u);
            l2 = blend(corner_dot(dims, perm_at(a + yi + 1), xf, y1, 0),
                       corner_dot(dims, perm_at(b + yi + 1), x1, y1, 0), u);
            r  = blend(l1, l2, v);
        end else begin
            a  = int'(perm_at(xi) + yi) & 255;
            aa = int'(perm_at(a) + zi) & 255;
            ab = int'(perm_at(a + 1) + zi) & 255;
            b  = int'(perm_at(xi + 1) + yi) & 255;
            ba = int'(perm_at(b) + zi) & 255;
            bb = int'(perm_at(b + 1) + zi) & 255;
            l1 = blend(corner_dot(dims, perm_at(aa), xf, yf, zf),
                       corner_dot(dims, perm_at(ba), x1, yf, zf), u);
            l2 = blend(corner_dot(dims, perm_at(ab), xf, y1, zf),
                       corner_dot(dims, perm_at(bb), x1, y1, zf), u);
            l3 = blend(corner_dot(dims, perm_at(aa + 1), xf, yf, z1),
                       corner_dot(dims, perm_at(ba + 1), x1, yf, z1), u);
            l4 = blend(corner_dot(dims, perm_at(ab + 1), xf, y1, z1),
                       corner_dot(dims, perm_at(bb + 1), x1, y1, z1), u);
            r  = blend(blend(l1, l2, v), blend(l3, l4, v), w);
        end
        // 16.16 down to Q2.14, then clamp
        r = r >>> SCALE_R;
        if (r > NOISE_MAX) r = NOISE_MAX;
        if (r < NOISE_MIN) r = NOISE_MIN;
        return NOISE_W'(r);
    endfunction

    // ---------------------------------------------------------------
    // Sender: one transaction per call. valid is only lowered when a
    // gap is taken, so it never gets two assignments in one step.
    // ---------------------------------------------------------------
    task automatic send_item(logic cmd, logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                             logic [COORD_W-1:0] cz, logic [7:0] idx, logic [7:0] val);
        if ($urandom_range(99) < send_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_gap_pct) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.command     <= cmd;
        in_ch.coord_x     <= cx;
        in_ch.coord_y     <= cy;
        in_ch.coord_z     <= cz;
        in_ch.entry_index <= idx;
        in_ch.entry_value <= val;
        do @(posedge i_clk); while (!in_ch.ready);
        if (cmd == CMD_LOAD)
            perm_copy[idx] = val;
        else
            noise_expected.push_back(predict_noise(cx, cy, cz));
    endtask

    task automatic load_entry(logic [7:0] idx, logic [7:0] val);
        send_item(CMD_LOAD, $urandom, $urandom, $urandom, idx, val);
    endtask

    task automatic evaluate_at(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                               logic [COORD_W-1:0] cz);
        send_item(CMD_EVAL, cx, cy, cz, 8'($urandom), 8'($urandom));
    endtask

    // drop valid, wait for all results, then let in-flight loads drain too
    task automatic drain_pipe();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (noise_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == DIMS_ADDR) dims_copy = DIM_W'(data);
    endtask

    task automatic set_dimensions(logic [31:0] data);
        drain_pipe();
        apb_write(DIMS_ADDR, data);
    endtask

    // ---------------------------------------------------------------
    // Result checking, receiver stalls and the watchdog
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, int want, int got);
        $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            if (out_ch.valid && out_ch.ready) begin
                if (noise_expected.size() == 0)
                    report_mismatch("unexpected noise result", 0, int'(out_ch.noise_value));
                else if (out_ch.noise_value !== noise_expected[0])
                    report_mismatch("noise_value", int'(noise_expected.pop_front()),
                                    int'(out_ch.noise_value));
                else
                    void'(noise_expected.pop_front());
            end
        end
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // whole table written before any evaluate; inner entries take values from
    // a shuffle of 0..255, with both value extremes at both index extremes
    task automatic test_table_fill();
        logic [7:0] shuffle [TABLE_ENTRIES];
        logic [7:0] tmp;
        int j;
        for (int i = 0; i < TABLE_ENTRIES; i++) shuffle[i] = 8'(i);
        for (int i = TABLE_ENTRIES - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = shuffle[i]; shuffle[i] = shuffle[j]; shuffle[j] = tmp;
        end
        load_entry(8'd0, 8'd255);
        for (int i = 1; i < TABLE_ENTRIES - 1; i++) load_entry(8'(i), shuffle[i]);
        load_entry(8'd255, 8'd0);
    endtask

    // coordinate extremes, fraction edges and lattice wrap in every mode
    task automatic test_coord_extremes();
        logic [COORD_W-1:0] pts [6] = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                        32'hFFFF_FFFF, 32'h0000_FFFF, 32'h00FF_8000};
        logic [31:0] dim_set [4] = '{DIM_THREE, DIM_ONE, DIM_TWO, 32'd0};
        foreach (dim_set[d]) begin
            set_dimensions(dim_set[d]);
            foreach (pts[p])
                evaluate_at(pts[p], pts[(p + 1) % 6], pts[(p + 3) % 6]);
        end
        // unmapped register must leave dimensions alone
        drain_pipe();
        apb_write(SPARE_ADDR, 32'h1);
        evaluate_at(32'h0001_4000, 32'hFFFE_C000, 32'h0003_2000);
    endtask

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(3))
            0: return $urandom;
            // a few cells either side of zero, exercises the cell wrap
            1: return COORD_W'($signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS));
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, $urandom_range(1) ? 16'hFFFF : 16'h0000};
            default: return {8'($urandom), 8'($urandom_range(255)), 16'($urandom)};
        endcase
    endfunction

    task automatic test_random_mix(int gap_pct, int stall_pct, logic [31:0] dims);
        send_gap_pct   = gap_pct;
        sink_stall_pct = stall_pct;
        set_dimensions(dims);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // mostly evaluates; occasional table rewrites keep it fully defined
            if ($urandom_range(9) == 0)
                load_entry(8'($urandom), 8'($urandom));
            else
                evaluate_at(pick_coord(), pick_coord(), pick_coord());
            // change mode part way through each run of items
            if (n == RANDOM_ITEMS / 2)
                set_dimensions(32'($urandom_range(DIM_THREE)));
        end
    endtask

    initial begin
        dims_copy = DIM_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_table_fill();
        test_coord_extremes();
        test_random_mix(37, 57, DIM_THREE);
        test_random_mix(57, 37, DIM_TWO);
        test_random_mix(0, 0, DIM_ONE);

        drain_pipe();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
